[sv/brn_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package brn_pkg;

  localparam int DEF_MAX_SRC_DIM   = 256;
  localparam int DEF_MAX_DST_DIM   = 256;
  localparam int DEF_OUT_FRAC_BITS = 12;

  // configuration port
  localparam int CFG_AW = 4;
  localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [1:0] REG_DST_SIZE   = 2'd2;

  localparam logic [8:0] RST_SRC_WIDTH  = 9'd256;
  localparam logic [8:0] RST_SRC_HEIGHT = 9'd256;
  localparam logic [8:0] RST_DST_SIZE   = 9'd224;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // channel statistics in thousandths
  localparam longint CH_MEAN_R = 123675;
  localparam longint CH_MEAN_G = 116280;
  localparam longint CH_MEAN_B = 103530;
  localparam longint CH_STD_R  = 58395;
  localparam longint CH_STD_G  = 57120;
  localparam longint CH_STD_B  = 57375;

  typedef struct packed {
    logic signed [15:0] norm_red;
    logic signed [15:0] norm_green;
    logic signed [15:0] norm_blue;
  } res_t;

  // normalized output for channel ch and pixel value r, rounded half up, saturated
  function automatic logic [15:0] norm_q(int ch, int r, int frac);
    longint num;
    longint x;
    longint q;
    begin
      q = 0;
      case (ch)
        0: begin
          num = (longint'(1000 * r) - CH_MEAN_R) <<< frac;
          x = 2 * num + CH_STD_R;
          if (x >= 0) q = x / (2 * CH_STD_R);
          else q = -((-x + 2 * CH_STD_R - 1) / (2 * CH_STD_R));
        end
        1: begin
          num = (longint'(1000 * r) - CH_MEAN_G) <<< frac;
          x = 2 * num + CH_STD_G;
          if (x >= 0) q = x / (2 * CH_STD_G);
          else q = -((-x + 2 * CH_STD_G - 1) / (2 * CH_STD_G));
        end
        default: begin
          num = (longint'(1000 * r) - CH_MEAN_B) <<< frac;
          x = 2 * num + CH_STD_B;
          if (x >= 0) q = x / (2 * CH_STD_B);
          else q = -((-x + 2 * CH_STD_B - 1) / (2 * CH_STD_B));
        end
      endcase
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[15:0];
    end
  endfunction

endpackage
`default_nettype wire

[sv/brn_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface brn_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic [7:0] target_x;
  logic [7:0] target_y;

  modport source (output valid, operation, red_in, green_in, blue_in, target_x, target_y,
                  input ready);
  modport sink (input valid, operation, red_in, green_in, blue_in, target_x, target_y,
                output ready);
endinterface
`default_nettype wire

[sv/brn_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface brn_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] norm_red;
  logic signed [15:0] norm_green;
  logic signed [15:0] norm_blue;

  modport source (output valid, norm_red, norm_green, norm_blue, input ready);
  modport sink (input valid, norm_red, norm_green, norm_blue, output ready);
endinterface
`default_nettype wire

[sv/brn_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module brn_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

[sv/bilinear_resize_rgb_normalize.sv]
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one request per cycle, loads and samples alike, while credits remain; a
// 16-entry result queue with credit count keeps the pipeline running while results
// wait downstream. After reset and after each register write a 25-step restoring
// divider per axis, with a common divisor, rebuilds both scales (one quotient bit per
// cycle); no request is accepted meanwhile. Reset (rst_n low, synchronous) restores
// register defaults and empties the pipeline.
module bilinear_resize_rgb_normalize #(
  parameter int MAX_SRC_DIM   = brn_pkg::DEF_MAX_SRC_DIM,
  parameter int MAX_DST_DIM   = brn_pkg::DEF_MAX_DST_DIM,
  parameter int OUT_FRAC_BITS = brn_pkg::DEF_OUT_FRAC_BITS
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  brn_in_if.sink                         in_ch,
  brn_out_if.source                      out_ch,
  input  wire logic                      cfg_psel,
  input  wire logic                      cfg_penable,
  input  wire logic                      cfg_pwrite,
  input  wire logic [brn_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0]               cfg_pwdata,
  output      logic [31:0]               cfg_prdata,
  output      logic                      cfg_pready
);
  import brn_pkg::*;

  // widths that follow from the dimension limits
  localparam int WB    = $clog2(MAX_SRC_DIM + 1);       // source dimension value
  localparam int XW    = $clog2(MAX_SRC_DIM);           // source coordinate
  localparam int DB    = $clog2(MAX_DST_DIM + 1);       // target size value
  localparam int SW    = WB + 16;                       // scale, Q.16
  localparam int DEPTH = MAX_SRC_DIM * MAX_SRC_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = $clog2(DEPTH + 1);
  localparam int T2W   = 9;                             // 2*t+1
  localparam int SSW   = T2W + SW + 1;                  // source coordinate, Q.17
  localparam int FW    = 18;                            // fraction, signed Q.17
  localparam int AVW   = 28;                            // row blend
  localparam int VW    = 48;                            // full blend, Q.34
  localparam int CW    = $clog2(SW + 1);
  localparam int FQ    = 16;                            // result queue depth
  localparam int QW    = $clog2(FQ);

  typedef struct packed {
    logic [XW-1:0]        lo;
    logic [XW-1:0]        hi;
    logic signed [FW-1:0] frac;
  } axis_t;

  // ---------------------------------------------------------------------------
  // configuration registers and derived scales
  // ---------------------------------------------------------------------------
  logic [8:0]    src_width_r, src_height_r, dst_size_r;
  logic [WB-1:0] eff_w, eff_h;
  logic [DB-1:0] eff_d;
  logic          cfg_wr;

  logic          div_go_r;
  logic [CW-1:0] div_cnt_r;
  logic [DB-1:0] dvs_r, remx_r, remy_r;
  logic [SW-1:0] qx_r, qy_r;
  logic [PW-1:0] frame_r;
  logic [DB:0]   trialx, trialy;
  logic          busy;

  function automatic logic [WB-1:0] clamp_src(logic [8:0] v);
    if (v == 9'd0) return WB'(1);
    if (int'(v) > MAX_SRC_DIM) return WB'(MAX_SRC_DIM);
    return WB'(v);
  endfunction

  always_comb begin
    eff_w = clamp_src(src_width_r);
    eff_h = clamp_src(src_height_r);
    if (dst_size_r == 9'd0) eff_d = DB'(1);
    else if (int'(dst_size_r) > MAX_DST_DIM) eff_d = DB'(MAX_DST_DIM);
    else eff_d = DB'(dst_size_r);
  end

  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_comb begin
    case (cfg_paddr[3:2])
      REG_SRC_WIDTH:  cfg_prdata = {23'd0, src_width_r};
      REG_SRC_HEIGHT: cfg_prdata = {23'd0, src_height_r};
      REG_DST_SIZE:   cfg_prdata = {23'd0, dst_size_r};
      default:        cfg_prdata = 32'd0;
    endcase
  end

  // restoring division: scale = (eff << 16) / eff_d, both axes side by side
  assign trialx = {remx_r, qx_r[SW-1]};
  assign trialy = {remy_r, qy_r[SW-1]};
  assign busy   = div_go_r || (div_cnt_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= RST_SRC_WIDTH;
      src_height_r <= RST_SRC_HEIGHT;
      dst_size_r   <= RST_DST_SIZE;
      div_go_r     <= 1'b1;
      div_cnt_r    <= '0;
    end else begin
      if (cfg_wr) begin
        case (cfg_paddr[3:2])
          REG_SRC_WIDTH:  src_width_r  <= cfg_pwdata[8:0];
          REG_SRC_HEIGHT: src_height_r <= cfg_pwdata[8:0];
          REG_DST_SIZE:   dst_size_r   <= cfg_pwdata[8:0];
          default: ;
        endcase
        div_go_r <= 1'b1;
      end else if (div_go_r) begin
        div_go_r  <= 1'b0;
        div_cnt_r <= CW'(SW);
      end else if (div_cnt_r != '0) begin
        div_cnt_r <= div_cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_go_r && !cfg_wr) begin
      qx_r    <= SW'(eff_w) << 16;
      qy_r    <= SW'(eff_h) << 16;
      remx_r  <= '0;
      remy_r  <= '0;
      dvs_r   <= eff_d;
      frame_r <= PW'(eff_w) * PW'(eff_h);
    end else if (div_cnt_r != '0) begin
      if (trialx >= {1'b0, dvs_r}) begin
        remx_r <= DB'(trialx - {1'b0, dvs_r});
        qx_r   <= {qx_r[SW-2:0], 1'b1};
      end else begin
        remx_r <= DB'(trialx);
        qx_r   <= {qx_r[SW-2:0], 1'b0};
      end
      if (trialy >= {1'b0, dvs_r}) begin
        remy_r <= DB'(trialy - {1'b0, dvs_r});
        qy_r   <= {qy_r[SW-2:0], 1'b1};
      end else begin
        remy_r <= DB'(trialy);
        qy_r   <= {qy_r[SW-2:0], 1'b0};
      end
    end
  end

  // ---------------------------------------------------------------------------
  // accept stage: target clamp, load pointer
  // ---------------------------------------------------------------------------
  logic [QW:0]    credit_r;
  logic           in_acc, out_acc, smp_acc, ld_acc;
  logic [AW-1:0]  lp_r, lp_nxt;
  logic [DB-1:0]  dmax;
  logic [7:0]     tx_c, ty_c;

  assign in_ch.ready = !busy && (credit_r < (QW + 1)'(FQ));
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign smp_acc     = in_acc && (in_ch.operation == OP_SAMPLE);
  assign ld_acc      = in_acc && (in_ch.operation == OP_LOAD);
  assign out_acc     = out_ch.valid && out_ch.ready;

  always_comb begin
    dmax = eff_d - DB'(1);
    tx_c = (int'(in_ch.target_x) > int'(dmax)) ? 8'(dmax) : in_ch.target_x;
    ty_c = (int'(in_ch.target_y) > int'(dmax)) ? 8'(dmax) : in_ch.target_y;
    if ((PW'(lp_r) + PW'(1)) >= frame_r) lp_nxt = '0;
    else lp_nxt = lp_r + AW'(1);
  end

  // count samples accepted and not yet delivered; bounds the result queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
      lp_r     <= '0;
    end else begin
      credit_r <= credit_r + (QW + 1)'(smp_acc) - (QW + 1)'(out_acc);
      if (ld_acc) lp_r <= lp_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline; loads travel along so the store write lines up with sample reads
  // ---------------------------------------------------------------------------
  logic                  s1_smp_r, s2_smp_r, s3_smp_r, s4_smp_r;
  logic                  s5_smp_r, s6_smp_r, s7_smp_r, s8_smp_r;
  logic                  s1_ld_r, s2_ld_r, s3_ld_r, s4_ld_r;
  logic [AW-1:0]         s1_wa_r, s2_wa_r, s3_wa_r, s4_wa_r;
  logic [23:0]           s1_px_r, s2_px_r, s3_px_r, s4_px_r;
  logic [T2W-1:0]        s1_t2x_r, s1_t2y_r;
  logic signed [SSW-1:0] s2_sx_r, s2_sy_r, sx_nxt, sy_nxt;
  logic [T2W+SW-1:0]     px_prod, py_prod;
  axis_t                 s3_ax_r, s3_ay_r, ax_nxt, ay_nxt;
  logic [AW-1:0]         s4_a_r [4];
  logic [AW-1:0]         a_nxt [4];
  logic signed [FW-1:0]  s4_dx_r, s4_dy_r, s5_dx_r, s5_dy_r, s6_dy_r;
  logic [23:0]           rd [4];
  logic signed [AVW-1:0] s6_a_r [3];
  logic signed [AVW-1:0] s6_b_r [3];
  logic signed [AVW-1:0] a_blend_nxt [3];
  logic signed [AVW-1:0] b_blend_nxt [3];
  logic signed [VW-1:0]  s7_v_r [3];
  logic signed [VW-1:0]  v_nxt [3];
  logic [7:0]            s8_r_r [3];
  logic [7:0]            r_nxt [3];

  function automatic axis_t axis_split(logic signed [SSW-1:0] s, logic [WB-1:0] len);
    logic signed [SSW-1:0] c;
    logic signed [SSW-1:0] lenm1;
    axis_t                 o;
    lenm1 = $signed(SSW'(len)) - SSW'(1);
    c = (s > 0) ? (s >>> 17) : '0;
    if (c > lenm1) c = lenm1;
    o.lo   = XW'(c);
    o.hi   = (c < lenm1) ? XW'(c + SSW'(1)) : XW'(lenm1);
    o.frac = FW'(s - (c <<< 17));
    return o;
  endfunction

  // s = (2t+1)*scale - 0.5 in Q.17
  always_comb begin
    px_prod = (T2W + SW)'(s1_t2x_r) * (T2W + SW)'(qx_r);
    py_prod = (T2W + SW)'(s1_t2y_r) * (T2W + SW)'(qy_r);
    sx_nxt  = $signed({1'b0, px_prod}) - SSW'(65536);
    sy_nxt  = $signed({1'b0, py_prod}) - SSW'(65536);
    ax_nxt  = axis_split(s2_sx_r, eff_w);
    ay_nxt  = axis_split(s2_sy_r, eff_h);
    // corner addresses: row * width + column
    a_nxt[0] = AW'(s3_ay_r.lo * eff_w + (XW + WB)'(s3_ax_r.lo));
    a_nxt[1] = AW'(s3_ay_r.lo * eff_w + (XW + WB)'(s3_ax_r.hi));
    a_nxt[2] = AW'(s3_ay_r.hi * eff_w + (XW + WB)'(s3_ax_r.lo));
    a_nxt[3] = AW'(s3_ay_r.hi * eff_w + (XW + WB)'(s3_ax_r.hi));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_smp_r <= 1'b0; s2_smp_r <= 1'b0; s3_smp_r <= 1'b0; s4_smp_r <= 1'b0;
      s5_smp_r <= 1'b0; s6_smp_r <= 1'b0; s7_smp_r <= 1'b0; s8_smp_r <= 1'b0;
      s1_ld_r  <= 1'b0; s2_ld_r  <= 1'b0; s3_ld_r  <= 1'b0; s4_ld_r  <= 1'b0;
    end else begin
      s1_smp_r <= smp_acc;  s2_smp_r <= s1_smp_r; s3_smp_r <= s2_smp_r;
      s4_smp_r <= s3_smp_r; s5_smp_r <= s4_smp_r; s6_smp_r <= s5_smp_r;
      s7_smp_r <= s6_smp_r; s8_smp_r <= s7_smp_r;
      s1_ld_r  <= ld_acc;   s2_ld_r  <= s1_ld_r;  s3_ld_r  <= s2_ld_r;
      s4_ld_r  <= s3_ld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_t2x_r <= {tx_c, 1'b1};
    s1_t2y_r <= {ty_c, 1'b1};
    s1_wa_r  <= lp_r;
    s1_px_r  <= {in_ch.red_in, in_ch.green_in, in_ch.blue_in};
    s2_sx_r  <= sx_nxt;
    s2_sy_r  <= sy_nxt;
    s2_wa_r  <= s1_wa_r;
    s2_px_r  <= s1_px_r;
    s3_ax_r  <= ax_nxt;
    s3_ay_r  <= ay_nxt;
    s3_wa_r  <= s2_wa_r;
    s3_px_r  <= s2_px_r;
    for (int i = 0; i < 4; i++) s4_a_r[i] <= a_nxt[i];
    s4_dx_r  <= s3_ax_r.frac;
    s4_dy_r  <= s3_ay_r.frac;
    s4_wa_r  <= s3_wa_r;
    s4_px_r  <= s3_px_r;
    s5_dx_r  <= s4_dx_r;
    s5_dy_r  <= s4_dy_r;
    s6_dy_r  <= s5_dy_r;
    for (int c = 0; c < 3; c++) begin
      s6_a_r[c] <= a_blend_nxt[c];
      s6_b_r[c] <= b_blend_nxt[c];
      s7_v_r[c] <= v_nxt[c];
      s8_r_r[c] <= r_nxt[c];
    end
  end

  // frame store: one copy per corner, all written by every load
  for (genvar k = 0; k < 4; k++) begin : g_bank
    brn_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_ram (
      .clk   (clk),
      .we    (s4_ld_r),
      .waddr (s4_wa_r),
      .wdata (s4_px_r),
      .raddr (s4_a_r[k]),
      .rdata (rd[k])
    );
  end

  // blend along x, then along y, then round half up and clamp
  always_comb begin
    logic [7:0]           v00, v01, v10, v11;
    logic signed [8:0]    d0, d1;
    logic signed [26:0]   pa, pb;
    logic signed [28:0]   dba;
    logic signed [46:0]   pv;
    logic signed [VW-1:0] t;
    for (int c = 0; c < 3; c++) begin
      v00 = rd[0][23 - 8 * c -: 8];
      v01 = rd[1][23 - 8 * c -: 8];
      v10 = rd[2][23 - 8 * c -: 8];
      v11 = rd[3][23 - 8 * c -: 8];
      d0  = $signed({1'b0, v01}) - $signed({1'b0, v00});
      d1  = $signed({1'b0, v11}) - $signed({1'b0, v10});
      pa  = d0 * s5_dx_r;
      pb  = d1 * s5_dx_r;
      a_blend_nxt[c] = $signed({3'b000, v00, 17'd0}) + AVW'(pa);
      b_blend_nxt[c] = $signed({3'b000, v10, 17'd0}) + AVW'(pb);
      dba = 29'(s6_b_r[c]) - 29'(s6_a_r[c]);
      pv  = dba * s6_dy_r;
      v_nxt[c] = (VW'(s6_a_r[c]) <<< 17) + VW'(pv);
      t = (s7_v_r[c] + (VW'(1) <<< 33)) >>> 34;
      if (s7_v_r[c] <= 0) r_nxt[c] = 8'd0;
      else if (t > VW'(255)) r_nxt[c] = 8'd255;
      else r_nxt[c] = 8'(t);
    end
  end

  // normalization tables, one per channel, built at elaboration
  logic [15:0] lut [3][256];
  for (genvar ch = 0; ch < 3; ch++) begin : g_lut_ch
    for (genvar i = 0; i < 256; i++) begin : g_lut_ent
      localparam logic [15:0] QV = norm_q(ch, i, OUT_FRAC_BITS);
      assign lut[ch][i] = QV;
    end
  end

  // ---------------------------------------------------------------------------
  // result queue
  // ---------------------------------------------------------------------------
  res_t        fifo_r [FQ];
  res_t        head;
  logic [QW:0] wptr_r, rptr_r;

  always_ff @(posedge clk) begin
    if (s8_smp_r) begin
      fifo_r[wptr_r[QW-1:0]] <= '{norm_red:   $signed(lut[0][s8_r_r[0]]),
                                  norm_green: $signed(lut[1][s8_r_r[1]]),
                                  norm_blue:  $signed(lut[2][s8_r_r[2]])};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
    end else begin
      if (s8_smp_r) wptr_r <= wptr_r + (QW + 1)'(1);
      if (out_acc) rptr_r <= rptr_r + (QW + 1)'(1);
    end
  end

  assign head              = fifo_r[rptr_r[QW-1:0]];
  assign out_ch.valid      = (wptr_r != rptr_r);
  assign out_ch.norm_red   = head.norm_red;
  assign out_ch.norm_green = head.norm_green;
  assign out_ch.norm_blue  = head.norm_blue;

endmodule
`default_nettype wire

[sv/brn_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module brn_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_red,
  input wire logic [15:0] out_green,
  input wire logic [15:0] out_blue,
  input wire logic        cfg_psel,
  input wire logic        cfg_penable,
  input wire logic        cfg_pwrite
);
  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_red) && $stable(out_green) && $stable(out_blue))
    else $error("stalled result changed");

  // scales are rebuilt after a register write; no request may slip in
  a_cfg_block: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel && cfg_penable && cfg_pwrite |=> !in_ready)
    else $error("request accepted while scales rebuild");

  // reset empties the result queue
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result present after reset");
endmodule

bind bilinear_resize_rgb_normalize brn_checker u_brn_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_red     (out_ch.norm_red),
  .out_green   (out_ch.norm_green),
  .out_blue    (out_ch.norm_blue),
  .cfg_psel    (cfg_psel),
  .cfg_penable (cfg_penable),
  .cfg_pwrite  (cfg_pwrite)
);
`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
  import brn_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  brn_in_if  in_ch ();
  brn_out_if out_ch ();

  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [31:0]       cfg_pwdata = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  bilinear_resize_rgb_normalize dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  localparam int LATENCY = 8;
  localparam int TIMEOUT_CYCLES = 900000;

  // predictor state: mirror of the frame store and the registers
  logic [23:0] pixel_mirror [0:65535];
  int unsigned load_ptr;
  int unsigned width_eff, height_eff, size_eff;
  longint scale_w, scale_h;

  res_t pixel_queue [$];
  int   mismatch_count = 0;
  int   cycle_count = 0;
  bit   idle_enable = 1'b1;

  // directed table: operation, bytes or target, optional typed-in result
  typedef struct {
    logic        op;
    logic [7:0]  a, b, c;
    bit          fixed;
    res_t        fixed_res;
  } dir_row_t;

  function automatic int unsigned clamp_dim(int unsigned v);
    if (v < 1) return 1;
    if (v > 256) return 256;
    return v;
  endfunction

  function automatic void set_register(logic [1:0] idx, logic [8:0] val);
    static int unsigned w_reg = 256, h_reg = 256, d_reg = 224;
    case (idx)
      REG_SRC_WIDTH:  w_reg = val;
      REG_SRC_HEIGHT: h_reg = val;
      REG_DST_SIZE:   d_reg = val;
      default: ;
    endcase
    width_eff = clamp_dim(w_reg);
    height_eff = clamp_dim(h_reg);
    size_eff = clamp_dim(d_reg);
    scale_w = (longint'(width_eff) << 16) / size_eff;
    scale_h = (longint'(height_eff) << 16) / size_eff;
  endfunction

  function automatic void corner(int unsigned t, longint sc, int unsigned len,
                                 output int unsigned lo, output int unsigned hi,
                                 output longint frac);
    longint s;
    s = longint'(2 * t + 1) * sc - 65536;
    lo = (s > 0) ? int'(s >>> 17) : 0;
    if (lo > len - 1) lo = len - 1;
    hi = (lo + 1 < len) ? lo + 1 : len - 1;
    frac = s - (longint'(lo) << 17);
  endfunction

  function automatic logic [15:0] normalize(longint r, longint mean, longint sd);
    longint num, x, q;
    num = (1000 * r - mean) * 4096;
    x = 2 * num + sd;
    q = (x >= 0) ? x / (2 * sd) : -((-x + 2 * sd - 1) / (2 * sd));
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic res_t predict_sample(logic [7:0] tx_in, logic [7:0] ty_in);
    int unsigned tx, ty, x0, x1, y0, y1;
    longint dx, dy, a, b, v, r;
    logic [23:0] p00, p01, p10, p11;
    longint means [3] = '{CH_MEAN_R, CH_MEAN_G, CH_MEAN_B};
    longint stds [3] = '{CH_STD_R, CH_STD_G, CH_STD_B};
    logic [15:0] outs [3];
    res_t res;
    tx = (tx_in > size_eff - 1) ? size_eff - 1 : tx_in;
    ty = (ty_in > size_eff - 1) ? size_eff - 1 : ty_in;
    corner(tx, scale_w, width_eff, x0, x1, dx);
    corner(ty, scale_h, height_eff, y0, y1, dy);
    p00 = pixel_mirror[(y0 * width_eff + x0) % 65536];
    p01 = pixel_mirror[(y0 * width_eff + x1) % 65536];
    p10 = pixel_mirror[(y1 * width_eff + x0) % 65536];
    p11 = pixel_mirror[(y1 * width_eff + x1) % 65536];
    for (int c = 0; c < 3; c++) begin
      longint v00, v01, v10, v11;
      v00 = p00[16 - 8 * c +: 8];
      v01 = p01[16 - 8 * c +: 8];
      v10 = p10[16 - 8 * c +: 8];
      v11 = p11[16 - 8 * c +: 8];
      a = v00 * 131072 + (v01 - v00) * dx;
      b = v10 * 131072 + (v11 - v10) * dx;
      v = a * 131072 + (b - a) * dy;
      r = 0;
      if (v > 0) begin
        r = (v + (longint'(1) << 33)) >>> 34;
        if (r > 255) r = 255;
      end
      outs[c] = normalize(r, means[c], stds[c]);
    end
    res.norm_red = outs[0];
    res.norm_green = outs[1];
    res.norm_blue = outs[2];
    return res;
  endfunction

  // advance the mirror on an accepted load, or queue the expected pixel for a sample
  function automatic void record_request(logic op, logic [7:0] a, logic [7:0] b,
                                         logic [7:0] c);
    if (op == OP_LOAD) begin
      pixel_mirror[load_ptr % 65536] = {a, b, c};
      load_ptr++;
      if (load_ptr >= width_eff * height_eff) load_ptr = 0;
    end else begin
      pixel_queue.insert(pixel_queue.size(), predict_sample(a, b));
    end
  endfunction

  // drop valid only when a gap follows
  task automatic idle_gap();
    int n;
    if (idle_enable && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 11);
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // drive one request and hold until the handshake completes
  task automatic send_request(logic op, logic [7:0] a, logic [7:0] b, logic [7:0] c);
    idle_gap();
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.red_in <= a;
    in_ch.green_in <= b;
    in_ch.blue_in <= c;
    in_ch.target_x <= a;
    in_ch.target_y <= b;
    do @(posedge clk); while (!in_ch.ready);
    record_request(op, a, b, c);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pixel_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_register(logic [1:0] idx, logic [8:0] val);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= CFG_AW'(4 * idx);
    cfg_pwdata <= 32'(val);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    set_register(idx, val);
  endtask

  task automatic configure(logic [8:0] w, logic [8:0] h, logic [8:0] d);
    write_register(REG_SRC_WIDTH, w);
    write_register(REG_SRC_HEIGHT, h);
    write_register(REG_DST_SIZE, d);
  endtask

  // fill a whole frame so no sample ever reads an unwritten entry
  task automatic fill_frame();
    int unsigned n;
    n = width_eff * height_eff;
    for (int unsigned i = 0; i < n; i++)
      send_request(OP_LOAD, $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 255));
  endtask

  task automatic random_samples(int n, int sample_pct);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < sample_pct)
        send_request(OP_SAMPLE, $urandom_range(0, 255), $urandom_range(0, 255), 8'd0);
      else
        send_request(OP_LOAD, $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 255));
    end
  endtask

  // result side: random stall bursts, compare against oldest expectation
  initial begin
    int stall;
    res_t got, want;
    out_ch.ready = 1'b0;
    stall = 0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        got.norm_red = out_ch.norm_red;
        got.norm_green = out_ch.norm_green;
        got.norm_blue = out_ch.norm_blue;
        if (pixel_queue.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected result %h", got);
        end else begin
          want = pixel_queue.pop_front();
          if (got.norm_red !== want.norm_red || got.norm_green !== want.norm_green ||
              got.norm_blue !== want.norm_blue) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                       want.norm_red, want.norm_green, want.norm_blue,
                       got.norm_red, got.norm_green, got.norm_blue);
          end
        end
      end
      if (stall > 0) stall--;
      else if (idle_enable && $urandom_range(0, 9) == 0) stall = $urandom_range(1, 11);
      out_ch.ready <= (stall == 0) && rst_n;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > TIMEOUT_CYCLES) begin
      $display("[bilinear_resize_rgb_normalize] ERROR");
      $finish;
    end
  end

  initial begin
    dir_row_t rows [$];
    dir_row_t row;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_LOAD;
    in_ch.red_in = '0;
    in_ch.green_in = '0;
    in_ch.blue_in = '0;
    in_ch.target_x = '0;
    in_ch.target_y = '0;
    load_ptr = 0;
    set_register(REG_DST_SIZE, RST_DST_SIZE);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // small 2x2 source to 4x4 target; extreme bytes, edges and saturation
    configure(9'd2, 9'd2, 9'd4);
    rows.insert(rows.size(), '{OP_LOAD, 8'd0, 8'd0, 8'd0, 0, '0});
    rows.insert(rows.size(), '{OP_LOAD, 8'd255, 8'd255, 8'd255, 0, '0});
    rows.insert(rows.size(), '{OP_LOAD, 8'd0, 8'd0, 8'd0, 0, '0});
    rows.insert(rows.size(), '{OP_LOAD, 8'd255, 8'd255, 8'd255, 0, '0});
    // top-left corner with negative fraction: clamps to black
    rows.insert(rows.size(), '{OP_SAMPLE, 8'd0, 8'd0, 8'd0, 1,
                               '{16'(-8675), 16'(-8338), 16'(-7391)}});
    rows.insert(rows.size(), '{OP_SAMPLE, 8'd3, 8'd3, 8'd0, 1,
                               '{16'(9212), 16'(9947), 16'(10813)}});
    rows.insert(rows.size(), '{OP_SAMPLE, 8'd1, 8'd2, 8'd0, 0, '0});
    rows.insert(rows.size(), '{OP_SAMPLE, 8'd2, 8'd1, 8'd0, 0, '0});
    // targets beyond dst_size saturate to the last pixel
    rows.insert(rows.size(), '{OP_SAMPLE, 8'd255, 8'd255, 8'd0, 0, '0});
    rows.insert(rows.size(), '{OP_SAMPLE, 8'hAA, 8'h55, 8'd0, 0, '0});
    rows.insert(rows.size(), '{OP_SAMPLE, 8'h55, 8'hAA, 8'd0, 0, '0});
    // load wrap: fifth load overwrites entry 0
    rows.insert(rows.size(), '{OP_LOAD, 8'hAA, 8'h55, 8'hF0, 0, '0});
    rows.insert(rows.size(), '{OP_LOAD, 8'h0F, 8'hC3, 8'h3C, 0, '0});
    rows.insert(rows.size(), '{OP_SAMPLE, 8'd0, 8'd0, 8'd0, 0, '0});
    rows.insert(rows.size(), '{OP_SAMPLE, 8'd1, 8'd1, 8'd0, 0, '0});
    foreach (rows[i]) begin
      row = rows[i];
      if (row.fixed) begin
        // typed-in expectations must agree with the predictor too
        if (predict_sample(row.a, row.b) !== row.fixed_res) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("directed row %0d disagrees", i);
        end
      end
      send_request(row.op, row.a, row.b, row.c);
    end
    drain();

    // random phases across settings, extremes and out-of-range values included
    configure(9'd1, 9'd1, 9'd1);
    fill_frame();
    random_samples(50, 70);
    drain();
    configure(9'd0, 9'd0, 9'd0);
    random_samples(40, 70);
    drain();
    configure(9'd16, 9'd8, 9'd256);
    fill_frame();
    random_samples(250, 75);
    // hold off until every pending result has arrived
    drain();
    configure(9'd7, 9'd13, 9'd3);
    fill_frame();
    random_samples(200, 75);
    drain();
    configure(9'd511, 9'd2, 9'd511);
    fill_frame();
    random_samples(150, 75);
    drain();
    configure($urandom_range(1, 24), $urandom_range(1, 24), $urandom_range(1, 256));
    fill_frame();
    random_samples(150, 75);
    idle_enable = 1'b0;
    random_samples(150, 75);
    drain();
    if (mismatch_count == 0 && pixel_queue.size() == 0) begin
      $display("[bilinear_resize_rgb_normalize] OK");
    end else begin
      $display("[bilinear_resize_rgb_normalize] ERROR");
    end
    $finish;
  end
endmodule
